### sv/sequence_gap_splitter_macros.svh
// Assertion macros shared by the sequence gap splitter checker.
`ifndef SEQUENCE_GAP_SPLITTER_MACROS_SVH
`define SEQUENCE_GAP_SPLITTER_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define SGS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define SGS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/sgs_pkg.sv
// Shared types, constants and helper functions of the sequence gap splitter.
package sgs_pkg;

  localparam int MAX_GAP     = 1024;
  localparam int CHUNK_WIDTH = 64;
  localparam int STORE_DEPTH = (MAX_GAP + CHUNK_WIDTH - 1) / CHUNK_WIDTH;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int BIT_W       = $clog2(CHUNK_WIDTH);
  localparam int RUN_W       = $clog2(MAX_GAP + 1);

  localparam int CFG_W    = 11;
  localparam int SYM_W    = 8;
  localparam int KIND_W   = 2;
  localparam int PIECE_W  = 16;
  localparam int LEN_W    = 7;
  localparam int MASK_W   = 64;

  localparam logic [CFG_W-1:0]   MIN_GAP_RESET = CFG_W'(1000);
  localparam logic [SYM_W-1:0]   CH_LOWER_N    = 8'h6E;
  localparam logic [SYM_W-1:0]   CH_UPPER_N    = 8'h4E;
  localparam logic [PIECE_W-1:0] PIECE_MAX     = {PIECE_W{1'b1}};

  localparam logic [KIND_W-1:0] KIND_CHAR  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_PIECE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CHUNK = 2'd2;
  localparam logic [KIND_W-1:0] KIND_END   = 2'd3;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [SYM_W-1:0]   out_symbol;
    logic [PIECE_W-1:0] piece_number;
    logic [LEN_W-1:0]   chunk_length;
    logic [MASK_W-1:0]  chunk_case_mask;
    logic               last;
  } out_item_t;

  typedef struct packed {
    logic                   en;
    logic [ADDR_W-1:0]      addr;
    logic [CHUNK_WIDTH-1:0] data;
  } store_wr_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
  } store_rd_t;

  function automatic out_item_t make_item(logic [KIND_W-1:0] kind,
                                          logic [SYM_W-1:0] sym,
                                          logic [PIECE_W-1:0] piece,
                                          logic [LEN_W-1:0] len,
                                          logic [MASK_W-1:0] mask,
                                          logic last);
    out_item_t it;
    it.kind            = kind;
    it.out_symbol      = sym;
    it.piece_number    = piece;
    it.chunk_length    = len;
    it.chunk_case_mask = mask;
    it.last            = last;
    return it;
  endfunction

  // Zero counts as one, anything above the run ceiling as the ceiling.
  function automatic logic [RUN_W-1:0] eff_gap(logic [CFG_W-1:0] g);
    logic [RUN_W-1:0] r;
    if (g == '0) begin
      r = RUN_W'(1);
    end else if (g > CFG_W'(MAX_GAP)) begin
      r = RUN_W'(MAX_GAP);
    end else begin
      r = RUN_W'(g);
    end
    return r;
  endfunction

endpackage

### sv/sgs_if.sv
// Channel interfaces of the sequence gap splitter: input, result and configuration.
interface sgs_in_if;
  import sgs_pkg::*;
  logic             valid;
  logic             ready;
  logic             action;
  logic [SYM_W-1:0] symbol;
  modport source(output valid, action, symbol, input ready);
  modport sink(input valid, action, symbol, output ready);
endinterface

interface sgs_out_if;
  import sgs_pkg::*;
  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  kind;
  logic [SYM_W-1:0]   out_symbol;
  logic [PIECE_W-1:0] piece_number;
  logic [LEN_W-1:0]   chunk_length;
  logic [MASK_W-1:0]  chunk_case_mask;
  logic               last;
  modport source(output valid, kind, out_symbol, piece_number, chunk_length,
                 chunk_case_mask, last, input ready);
  modport sink(input valid, kind, out_symbol, piece_number, chunk_length,
               chunk_case_mask, last, output ready);
endinterface

interface sgs_cfg_if;
  import sgs_pkg::*;
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] min_gap;
  modport source(output valid, min_gap, input ready);
  modport sink(input valid, min_gap, output ready);
endinterface

### sv/sequence_gap_splitter.sv
// Sequence gap splitter top level: configuration register, sequencer and case store.
// Ordinary characters and N characters are taken back to back while results
// are not stalled. A character that ends a long run is sent as a piece start,
// then the character, as is the first character of a sequence and an end
// marker at the start of a sequence. A character or end marker that replays a
// short run goes through these steps: the accepting cycle reads the first case
// word, the case store has one read port and delivers one 64-character chunk
// per cycle, while results are taken, into the single output register, and the
// final transaction follows the last chunk. A stalled result holds the block
// until it is taken. The case store needs no clearing pass after reset.
module sequence_gap_splitter (
  input  logic      clk,
  input  logic      rst_n,
  sgs_in_if.sink    in_ch,
  sgs_out_if.source out_ch,
  sgs_cfg_if.sink   cfg_ch
);
  import sgs_pkg::*;

  logic [RUN_W-1:0]       gap_r;
  store_wr_t              wr;
  store_rd_t              rd;
  logic [CHUNK_WIDTH-1:0] rd_data;

  assign cfg_ch.ready = 1'b1;

  // The clamped threshold is kept rather than the raw register value.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_r <= eff_gap(MIN_GAP_RESET);
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      gap_r <= eff_gap(cfg_ch.min_gap);
    end
  end

  sgs_seq u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .gap     (gap_r),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .wr      (wr),
    .rd      (rd),
    .rd_data (rd_data)
  );

  sgs_case_store u_store (
    .clk     (clk),
    .wr      (wr),
    .rd      (rd),
    .rd_data (rd_data)
  );

endmodule

### sv/sgs_case_store.sv
// Case store: one 64-bit word per chunk of the current N run, registered read.
module sgs_case_store (
  input  logic                           clk,
  input  sgs_pkg::store_wr_t             wr,
  input  sgs_pkg::store_rd_t             rd,
  output logic [sgs_pkg::CHUNK_WIDTH-1:0] rd_data
);
  import sgs_pkg::*;

  logic [CHUNK_WIDTH-1:0] mem [STORE_DEPTH];
  logic [CHUNK_WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // The read word holds while no read is issued, so a stalled chunk keeps its mask.
  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_data_r <= mem[rd.addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### sv/sgs_seq.sv
// Sequencer: run tracking, piece numbering, chunk replay and the output register.
module sgs_seq (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [sgs_pkg::RUN_W-1:0]       gap,
  sgs_in_if.sink                          in_ch,
  sgs_out_if.source                       out_ch,
  output sgs_pkg::store_wr_t              wr,
  output sgs_pkg::store_rd_t              rd,
  input  logic [sgs_pkg::CHUNK_WIDTH-1:0] rd_data
);
  import sgs_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_EMIT  = 2'd1;
  localparam logic [1:0] ST_FINAL = 2'd2;

  logic [1:0]             state_r, state_nxt;
  logic                   at_start_r, at_start_nxt;
  logic [RUN_W-1:0]       run_r, run_nxt;
  logic [PIECE_W-1:0]     pieces_r, pieces_nxt;
  logic [CHUNK_WIDTH-1:0] cur_word_r, cur_word_nxt;
  logic [RUN_W-1:0]       rem_r, rem_nxt;
  logic [ADDR_W-1:0]      k_r, k_nxt;
  logic                   fin_end_r, fin_end_nxt;
  logic [SYM_W-1:0]       fin_sym_r, fin_sym_nxt;
  logic                   out_valid_r, out_valid_nxt;
  out_item_t              out_r, out_nxt;

  logic                   emit_ok;
  logic                   accept;
  logic                   is_n;
  logic                   run_nz;
  logic                   run_long;
  logic [BIT_W-1:0]       bit_pos;
  logic [LEN_W-1:0]       chunk_len;
  logic [MASK_W-1:0]      chunk_mask;
  logic [PIECE_W-1:0]     pieces_inc;

  assign emit_ok    = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == ST_IDLE) && emit_ok;
  assign accept     = in_ch.valid && in_ch.ready;
  assign is_n       = (in_ch.symbol == CH_LOWER_N) || (in_ch.symbol == CH_UPPER_N);
  assign run_nz     = (run_r != '0);
  assign run_long   = (run_r >= gap);
  assign bit_pos    = run_r[BIT_W-1:0];
  assign chunk_len  = (rem_r > RUN_W'(CHUNK_WIDTH)) ? LEN_W'(CHUNK_WIDTH) : rem_r[LEN_W-1:0];
  assign chunk_mask = rd_data & ~({MASK_W{1'b1}} << chunk_len);
  assign pieces_inc = (pieces_r == PIECE_MAX) ? pieces_r : pieces_r + PIECE_W'(1);

  always_comb begin
    state_nxt     = state_r;
    at_start_nxt  = at_start_r;
    run_nxt       = run_r;
    pieces_nxt    = pieces_r;
    cur_word_nxt  = cur_word_r;
    rem_nxt       = rem_r;
    k_nxt         = k_r;
    fin_end_nxt   = fin_end_r;
    fin_sym_nxt   = fin_sym_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_nxt       = out_r;
    wr            = '{en: 1'b0, addr: run_r[BIT_W +: ADDR_W], data: cur_word_r};
    rd            = '{en: 1'b0, addr: k_r};

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_ch.action) begin
            fin_end_nxt = 1'b1;
            if (at_start_r) begin
              out_valid_nxt = 1'b1;
              out_nxt = make_item(KIND_PIECE, '0, pieces_r, '0, '0, 1'b0);
              state_nxt = ST_FINAL;
            end else if (run_nz && !run_long) begin
              rd = '{en: 1'b1, addr: '0};
              k_nxt = '0;
              rem_nxt = run_r;
              state_nxt = ST_EMIT;
            end else begin
              out_valid_nxt = 1'b1;
              out_nxt = make_item(KIND_END, '0, '0, '0, '0, 1'b1);
            end
            at_start_nxt = 1'b1;
            run_nxt = '0;
            pieces_nxt = '0;
          end else if (at_start_r) begin
            out_valid_nxt = 1'b1;
            out_nxt = make_item(KIND_PIECE, '0, '0, '0, '0, 1'b0);
            pieces_nxt = PIECE_W'(1);
            fin_end_nxt = 1'b0;
            fin_sym_nxt = in_ch.symbol;
            state_nxt = ST_FINAL;
            at_start_nxt = 1'b0;
            run_nxt = '0;
          end else if (is_n) begin
            if (run_r < RUN_W'(MAX_GAP)) begin
              // The word under construction lives in cur_word_r, so no read-back
              // is needed; each character writes the updated word through.
              cur_word_nxt = (bit_pos == '0) ? '0 : cur_word_r;
              cur_word_nxt[bit_pos] = (in_ch.symbol == CH_LOWER_N);
              wr = '{en: 1'b1, addr: run_r[BIT_W +: ADDR_W], data: cur_word_nxt};
              run_nxt = run_r + RUN_W'(1);
            end
          end else begin
            fin_end_nxt = 1'b0;
            fin_sym_nxt = in_ch.symbol;
            if (run_nz && run_long) begin
              out_valid_nxt = 1'b1;
              out_nxt = make_item(KIND_PIECE, '0, pieces_r, '0, '0, 1'b0);
              pieces_nxt = pieces_inc;
              state_nxt = ST_FINAL;
            end else if (run_nz) begin
              rd = '{en: 1'b1, addr: '0};
              k_nxt = '0;
              rem_nxt = run_r;
              state_nxt = ST_EMIT;
            end else begin
              out_valid_nxt = 1'b1;
              out_nxt = make_item(KIND_CHAR, in_ch.symbol, '0, '0, '0, 1'b1);
            end
            run_nxt = '0;
          end
        end
      end
      ST_EMIT: begin
        if (emit_ok) begin
          out_valid_nxt = 1'b1;
          out_nxt = make_item(KIND_CHUNK, '0, '0, chunk_len, chunk_mask, 1'b0);
          if (rem_r > RUN_W'(CHUNK_WIDTH)) begin
            rem_nxt = rem_r - RUN_W'(CHUNK_WIDTH);
            k_nxt = k_r + ADDR_W'(1);
            rd = '{en: 1'b1, addr: k_r + ADDR_W'(1)};
          end else begin
            state_nxt = ST_FINAL;
          end
        end
      end
      ST_FINAL: begin
        if (emit_ok) begin
          out_valid_nxt = 1'b1;
          out_nxt = fin_end_r ? make_item(KIND_END, '0, '0, '0, '0, 1'b1)
                              : make_item(KIND_CHAR, fin_sym_r, '0, '0, '0, 1'b1);
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      at_start_r  <= 1'b1;
      run_r       <= '0;
      pieces_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      at_start_r  <= at_start_nxt;
      run_r       <= run_nxt;
      pieces_r    <= pieces_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_word_r <= cur_word_nxt;
    rem_r      <= rem_nxt;
    k_r        <= k_nxt;
    fin_end_r  <= fin_end_nxt;
    fin_sym_r  <= fin_sym_nxt;
    out_r      <= out_nxt;
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.kind            = out_r.kind;
  assign out_ch.out_symbol      = out_r.out_symbol;
  assign out_ch.piece_number    = out_r.piece_number;
  assign out_ch.chunk_length    = out_r.chunk_length;
  assign out_ch.chunk_case_mask = out_r.chunk_case_mask;
  assign out_ch.last            = out_r.last;

endmodule

### sv/sgs_checker.sv
// Port-level checker for the sequence gap splitter and its bind statement.
`include "sequence_gap_splitter_macros.svh"

module sgs_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [sgs_pkg::KIND_W-1:0]   out_kind,
  input logic [sgs_pkg::LEN_W-1:0]    out_chunk_length,
  input logic [sgs_pkg::MASK_W-1:0]   out_chunk_case_mask,
  input logic                         out_last
);
  import sgs_pkg::*;

  `SGS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_kind) && $stable(out_last), "stalled result changed")
  `SGS_ASSERT_NOW(a_no_take_on_stall, out_valid && !out_ready, !in_ready, "input taken while a result is stalled")
  `SGS_ASSERT_NOW(a_chunk_len, out_valid && (out_kind == KIND_CHUNK), (out_chunk_length != '0) && (out_chunk_length <= LEN_W'(CHUNK_WIDTH)) && !out_last, "bad chunk transaction")
  `SGS_ASSERT_NOW(a_end_last, out_valid && (out_kind == KIND_END), out_last && (out_chunk_case_mask == '0), "end of sequence not final")
  `SGS_ASSERT_NOW(a_piece_not_last, out_valid && (out_kind == KIND_PIECE), !out_last && (out_chunk_length == '0), "piece start marked final")

endmodule

bind sequence_gap_splitter sgs_checker u_sgs_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_ready            (in_ch.ready),
  .out_valid           (out_ch.valid),
  .out_ready           (out_ch.ready),
  .out_kind            (out_ch.kind),
  .out_chunk_length    (out_ch.chunk_length),
  .out_chunk_case_mask (out_ch.chunk_case_mask),
  .out_last            (out_ch.last)
);

### sim/sequence_gap_splitter_tb.sv
// Self-checking testbench of the sequence gap splitter: predicts every result and compares it.
module sequence_gap_splitter_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sgs_pkg::*;

  localparam int QUIET_LIMIT   = 4000;
  localparam int SETTLE_CYCLES = 24;
  localparam int GAP_PCT       = 31;
  localparam int HOLD_CYCLES   = 400;
  localparam int PIECE_COUNT   = 20;
  localparam int RANDOM_COUNT  = 24;

  logic clk = 1'b0;
  logic rst_n;

  sgs_in_if  in_ch();
  sgs_out_if out_ch();
  sgs_cfg_if cfg_ch();

  sequence_gap_splitter u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state, mirroring the block.
  logic [CFG_W-1:0]       gap_reg;
  logic                   seq_start;
  int unsigned            run_len;
  logic [PIECE_W-1:0]     piece_next;
  logic [CHUNK_WIDTH-1:0] case_words [STORE_DEPTH];
  out_item_t              pending_results [$];

  int unsigned fail_count;
  int unsigned mismatch_shown;
  bit          src_gaps;
  bit          sink_gaps;
  int unsigned hold_left;

  function automatic void push_result(logic [KIND_W-1:0] kind, logic [SYM_W-1:0] sym,
                                      logic [PIECE_W-1:0] piece, logic [LEN_W-1:0] len,
                                      logic [MASK_W-1:0] mask);
    out_item_t r;
    r.kind            = kind;
    r.out_symbol      = sym;
    r.piece_number    = piece;
    r.chunk_length    = len;
    r.chunk_case_mask = mask;
    r.last            = 1'b0;
    pending_results.push_back(r);
  endfunction

  function automatic void push_piece_start();
    push_result(KIND_PIECE, '0, piece_next, '0, '0);
    if (piece_next != PIECE_MAX) piece_next++;
  endfunction

  function automatic int unsigned split_threshold();
    int unsigned g;
    g = gap_reg;
    if (g == 0) g = 1;
    if (g > MAX_GAP) g = MAX_GAP;
    return g;
  endfunction

  function automatic void push_replay();
    int unsigned done;
    int unsigned len;
    int unsigned k;
    logic [MASK_W-1:0] mask;
    done = 0;
    k = 0;
    while (done < run_len && k < STORE_DEPTH) begin
      len = run_len - done;
      if (len > CHUNK_WIDTH) len = CHUNK_WIDTH;
      mask = case_words[k];
      if (len < MASK_W) mask &= (64'd1 << len) - 64'd1;
      push_result(KIND_CHUNK, '0, '0, LEN_W'(len), mask);
      done += len;
      k++;
    end
  endfunction

  // Works out the results of one accepted transaction and queues them.
  function automatic void split_predict(logic act, logic [SYM_W-1:0] sym);
    int unsigned first;
    int unsigned w;
    int unsigned b;
    first = pending_results.size();
    if (act) begin
      if (seq_start) begin
        push_piece_start();
      end else if (run_len < split_threshold()) begin
        push_replay();
      end
      push_result(KIND_END, '0, '0, '0, '0);
      seq_start  = 1'b1;
      run_len    = 0;
      piece_next = '0;
    end else if (seq_start) begin
      piece_next = '0;
      push_piece_start();
      push_result(KIND_CHAR, sym, '0, '0, '0);
      seq_start = 1'b0;
      run_len   = 0;
    end else if (sym == CH_LOWER_N || sym == CH_UPPER_N) begin
      // Runs stop growing at the ceiling; the extra characters are not kept.
      if (run_len < MAX_GAP) begin
        w = run_len / CHUNK_WIDTH;
        b = run_len % CHUNK_WIDTH;
        if (b == 0) case_words[w] = '0;
        if (sym == CH_LOWER_N) case_words[w][b] = 1'b1;
        run_len++;
      end
    end else begin
      if (run_len > 0) begin
        if (run_len >= split_threshold()) begin
          push_piece_start();
        end else begin
          push_replay();
        end
      end
      push_result(KIND_CHAR, sym, '0, '0, '0);
      run_len = 0;
    end
    if (pending_results.size() > first) begin
      pending_results[pending_results.size() - 1].last = 1'b1;
    end
  endfunction

  function automatic logic [SYM_W-1:0] rand_base();
    logic [SYM_W-1:0] b;
    do b = SYM_W'($urandom); while (b == CH_LOWER_N || b == CH_UPPER_N);
    return b;
  endfunction

  function automatic logic [SYM_W-1:0] rand_n();
    return ($urandom_range(0, 1) != 0) ? CH_LOWER_N : CH_UPPER_N;
  endfunction

  task automatic send_item(input logic act, input logic [SYM_W-1:0] sym);
    while (src_gaps && $urandom_range(0, 99) < GAP_PCT) begin
      @(negedge clk);
      in_ch.valid  <= 1'b0;
      in_ch.action <= 1'($urandom);
      in_ch.symbol <= SYM_W'($urandom);
    end
    @(negedge clk);
    in_ch.valid  <= 1'b1;
    in_ch.action <= act;
    in_ch.symbol <= sym;
    do @(posedge clk); while (!in_ch.ready);
    split_predict(act, sym);
  endtask

  task automatic send_run(input int unsigned len);
    repeat (len) send_item(1'b0, rand_n());
  endtask

  // Stops offering and waits until every queued result has arrived.
  task automatic wait_idle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_min_gap(input logic [CFG_W-1:0] value);
    wait_idle();
    @(negedge clk);
    cfg_ch.valid   <= 1'b1;
    cfg_ch.min_gap <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    gap_reg = value;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Mostly well-formed sequences: bases, runs around the split length, end markers.
  task automatic send_random_items(input int unsigned count);
    int unsigned sent;
    int unsigned len;
    int unsigned pick;
    int unsigned g;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(0, 99);
      g = split_threshold();
      if (pick < 15) begin
        send_item(1'($urandom_range(0, 7) == 0), SYM_W'($urandom));
        sent++;
      end else if (pick < 25) begin
        send_item(1'b1, SYM_W'($urandom));
        sent++;
      end else if (pick < 60) begin
        send_item(1'b0, rand_base());
        sent++;
      end else begin
        case ($urandom_range(0, 4))
          0: len = $urandom_range(1, 3);
          1: len = (g > 1) ? g - 1 : 1;
          2: len = g;
          3: len = g + 1;
          default: len = $urandom_range(60, 70);
        endcase
        if (len > 140) len = $urandom_range(1, 3);
        send_run(len);
        sent += len;
      end
    end
  endtask

  task automatic test_reset_setting();
    send_item(1'b1, 8'hFF);
    send_item(1'b0, CH_UPPER_N);
    send_item(1'b0, CH_LOWER_N);
    send_item(1'b0, CH_LOWER_N);
    send_item(1'b0, CH_UPPER_N);
    send_item(1'b0, 8'h00);
    send_item(1'b0, 8'hFF);
    send_item(1'b0, CH_LOWER_N);
    send_item(1'b1, 8'h00);
  endtask

  task automatic test_zero_gap();
    set_min_gap('0);
    send_item(1'b0, 8'h41);
    send_item(1'b0, CH_UPPER_N);
    send_item(1'b0, 8'h7F);
    send_item(1'b0, CH_LOWER_N);
    send_item(1'b0, CH_UPPER_N);
    send_item(1'b1, 8'h80);
  endtask

  task automatic test_gap_boundary();
    set_min_gap(CFG_W'(3));
    send_item(1'b0, 8'h41);
    send_run(2);
    send_item(1'b0, 8'h43);
    send_run(3);
    send_item(1'b0, 8'h47);
    send_item(1'b1, 8'h55);
  endtask

  // The threshold clamps to the run ceiling, so both runs here are replayed.
  task automatic test_widest_gap();
    set_min_gap({CFG_W{1'b1}});
    send_item(1'b0, 8'h41);
    send_run(CHUNK_WIDTH + 36);
    send_item(1'b0, 8'h43);
    send_run(5);
    send_item(1'b1, 8'h00);
    wait_idle();
  endtask

  // One sequence split into many pieces, numbered in order.
  task automatic test_piece_numbering();
    set_min_gap(CFG_W'(1));
    src_gaps  = 1'b0;
    sink_gaps = 1'b0;
    send_item(1'b0, 8'h41);
    repeat (PIECE_COUNT) begin
      send_item(1'b0, CH_UPPER_N);
      send_item(1'b0, rand_base());
    end
    send_item(1'b1, 8'h00);
    wait_idle();
    src_gaps  = 1'b1;
    sink_gaps = 1'b1;
  endtask

  task automatic test_backpressure();
    set_min_gap(CFG_W'(5));
    hold_left = HOLD_CYCLES;
    send_random_items(60);
    wait_idle();
  endtask

  task automatic test_random_traffic();
    set_min_gap(CFG_W'(1));
    send_random_items(RANDOM_COUNT);
    set_min_gap(CFG_W'(2));
    send_random_items(RANDOM_COUNT);
    set_min_gap(CFG_W'(CHUNK_WIDTH));
    send_random_items(RANDOM_COUNT);
    set_min_gap(CFG_W'(CHUNK_WIDTH + 1));
    src_gaps  = 1'b0;
    sink_gaps = 1'b0;
    send_random_items(RANDOM_COUNT);
    wait_idle();
    src_gaps  = 1'b1;
    sink_gaps = 1'b1;
    set_min_gap(CFG_W'(MAX_GAP));
    send_random_items(RANDOM_COUNT);
    set_min_gap(MIN_GAP_RESET);
    send_random_items(RANDOM_COUNT);
    set_min_gap(CFG_W'($urandom_range(3, 130)));
    send_random_items(RANDOM_COUNT);
    wait_idle();
  endtask

  // Receiver: a requested hold-off first, otherwise random stalls.
  always @(negedge clk) begin
    if (hold_left != 0) begin
      out_ch.ready <= 1'b0;
      hold_left--;
    end else begin
      out_ch.ready <= !(sink_gaps && $urandom_range(0, 99) < GAP_PCT);
    end
  end

  always @(posedge clk) begin
    out_item_t seen;
    out_item_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      seen.kind            = out_ch.kind;
      seen.out_symbol      = out_ch.out_symbol;
      seen.piece_number    = out_ch.piece_number;
      seen.chunk_length    = out_ch.chunk_length;
      seen.chunk_case_mask = out_ch.chunk_case_mask;
      seen.last            = out_ch.last;
      if (pending_results.size() == 0) begin
        fail_count++;
        if (mismatch_shown < 10) begin
          mismatch_shown++;
          $display("unexpected result: kind %0d sym %h piece %0d len %0d mask %h last %0d",
                   seen.kind, seen.out_symbol, seen.piece_number, seen.chunk_length,
                   seen.chunk_case_mask, seen.last);
        end
      end else begin
        want = pending_results.pop_front();
        if (seen.kind !== want.kind || seen.out_symbol !== want.out_symbol ||
            seen.piece_number !== want.piece_number ||
            seen.chunk_length !== want.chunk_length ||
            seen.chunk_case_mask !== want.chunk_case_mask || seen.last !== want.last) begin
          fail_count++;
          if (mismatch_shown < 10) begin
            mismatch_shown++;
            $display("mismatch: expected kind %0d sym %h piece %0d len %0d mask %h last %0d",
                     want.kind, want.out_symbol, want.piece_number, want.chunk_length,
                     want.chunk_case_mask, want.last);
            $display("          actual   kind %0d sym %h piece %0d len %0d mask %h last %0d",
                     seen.kind, seen.out_symbol, seen.piece_number, seen.chunk_length,
                     seen.chunk_case_mask, seen.last);
          end
        end
      end
    end
  end

  // Ends the run when no transaction has happened on any channel for too long.
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.action   = 1'b0;
    in_ch.symbol   = '0;
    out_ch.ready   = 1'b0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.min_gap = MIN_GAP_RESET;
    gap_reg        = MIN_GAP_RESET;
    seq_start      = 1'b1;
    run_len        = 0;
    piece_next     = '0;
    foreach (case_words[i]) case_words[i] = '0;
    fail_count     = 0;
    mismatch_shown = 0;
    src_gaps       = 1'b1;
    sink_gaps      = 1'b1;
    hold_left      = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_setting();
    test_zero_gap();
    test_gap_boundary();
    test_widest_gap();
    test_piece_numbering();
    test_backpressure();
    test_random_traffic();

    wait_idle();
    fail_count += pending_results.size();
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### sequence_gap_splitter.f
+incdir+sv
sv/sgs_pkg.sv
sv/sgs_if.sv
sv/sgs_case_store.sv
sv/sgs_seq.sv
sv/sequence_gap_splitter.sv
sv/sgs_checker.sv
sim/sequence_gap_splitter_tb.sv
